### rtl/ils_pkg.sv
// ----------------------------------------------------------------------------
// ils_pkg: shared types and codes of the indexed list store
// Command and result payloads, command and status codes, and the control
// word that the sequencer broadcasts along the row of storage cells.
// ----------------------------------------------------------------------------
package ils_pkg;

  localparam int DATA_W   = 32;
  localparam int CMD_W    = 3;
  localparam int POS_W    = 12;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 11;

  // command codes
  localparam logic [CMD_W-1:0] CMD_READ      = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INS_AT    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_INS_FRONT = 3'd2;
  localparam logic [CMD_W-1:0] CMD_INS_BACK  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DELETE    = 3'd4;

  // status codes
  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // value returned by a read or delete out of range
  localparam logic [DATA_W-1:0] MISS_VALUE = '1;

  typedef struct packed {
    logic [CMD_W-1:0]         cmd;
    logic signed [POS_W-1:0]  position;
    logic signed [DATA_W-1:0] value_in;
  } cmd_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] read_value;
    logic [STATUS_W-1:0]      status;
    logic [COUNT_W-1:0]       item_count;
  } result_t;

  // control word broadcast to every cell
  typedef struct packed {
    logic              insert;     // open a slot at the position and fill it
    logic              remove;     // close the slot at the position
    logic              load_pipe;  // copy every value into its read pipe stage
    logic              shift_pipe; // move the read pipe one cell toward cell 0
    logic [DATA_W-1:0] data;       // value written by an insert
  } cell_ctrl_t;

endpackage

### rtl/ils_cell.sv
// ----------------------------------------------------------------------------
// ils_cell: one storage cell of the list row
// Holds one value and one read pipe stage; takes its left neighbor's value
// on an insert, its right neighbor's value on a delete.
// ----------------------------------------------------------------------------
module ils_cell #(
  parameter int INDEX = 0,
  parameter int IDX_W = 12
) (
  input  logic                     clk,
  input  ils_pkg::cell_ctrl_t      ctrl,
  input  logic [IDX_W-1:0]         pos,
  input  logic [ils_pkg::DATA_W-1:0] left_value,
  input  logic [ils_pkg::DATA_W-1:0] right_value,
  input  logic [ils_pkg::DATA_W-1:0] right_pipe,
  output logic [ils_pkg::DATA_W-1:0] value,
  output logic [ils_pkg::DATA_W-1:0] pipe
);

  localparam logic [IDX_W-1:0] IDX = IDX_W'(INDEX);

  // value shifts for insert and delete
  always_ff @(posedge clk) begin
    if (ctrl.insert) begin
      if (IDX > pos) begin
        value <= left_value;
      end else if (IDX == pos) begin
        value <= ctrl.data;
      end
    end else if (ctrl.remove) begin
      if (IDX >= pos) begin
        value <= right_value;
      end
    end
  end

  // read pipe: parallel load, then shift toward cell 0
  always_ff @(posedge clk) begin
    if (ctrl.load_pipe) begin
      pipe <= value;
    end else if (ctrl.shift_pipe) begin
      pipe <= right_pipe;
    end
  end

endmodule

### rtl/indexed_list_store.sv
// ----------------------------------------------------------------------------
// indexed_list_store: ordered store of signed 32-bit values
// A row of CAPACITY cells that shift in parallel on insert and delete; reads
// travel to cell 0 through a read pipe that runs along the row.
//
//   channel   ports                  transfer
//   command   start, busy, command   rising edge with start high, busy low
//   result    done, result           rising edge that ends the done cycle
//
// Insert, delete, a rejected command and a read out of range never raise busy:
// the result strobes in the next cycle and a new command may follow at once.
// A read at position p moves the read pipe one cell per cycle toward cell 0;
// busy is high while it runs.
// Reset clears the count, busy and the strobe; cell contents stay undefined
// until written. The receiver cannot stall, so results never wait.
// ----------------------------------------------------------------------------
module indexed_list_store #(
  parameter int CAPACITY = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  ils_pkg::cmd_t        command,
  output logic                 done,
  output ils_pkg::result_t     result
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > ils_pkg::POS_W) ? CNT_W : ils_pkg::POS_W;
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(CAPACITY);

  logic [CNT_W-1:0]           length;
  logic [CNT_W-1:0]           length_next;
  logic [CMP_W-1:0]           read_left;
  logic                       accept;
  logic                       negative;
  logic [CMP_W-1:0]           pos_mag;
  logic [CMP_W-1:0]           len_x;
  logic [CMP_W-1:0]           len_next_x;
  logic [CMP_W-1:0]           cell_pos;
  logic                       read_go;
  logic                       quick_done;
  logic [ils_pkg::DATA_W-1:0] quick_value;
  logic [ils_pkg::STATUS_W-1:0] quick_status;
  ils_pkg::cell_ctrl_t        ctrl;

  logic [ils_pkg::DATA_W-1:0] cell_value [CAPACITY];
  logic [ils_pkg::DATA_W-1:0] cell_pipe  [CAPACITY];

  assign accept     = start && !busy;
  assign negative   = command.position[ils_pkg::POS_W-1];
  assign pos_mag    = negative ? '0
                      : CMP_W'(command.position[ils_pkg::POS_W-2:0]);
  assign len_x      = CMP_W'(length);
  assign len_next_x = CMP_W'(length_next);

  // command decode
  always_comb begin
    ctrl         = '0;
    ctrl.data    = command.value_in;
    cell_pos     = pos_mag;
    length_next  = length;
    read_go      = 1'b0;
    quick_done   = 1'b0;
    quick_value  = '0;
    quick_status = ils_pkg::ST_DONE;
    if (accept) begin
      quick_done = 1'b1;
      unique case (command.cmd)
        ils_pkg::CMD_READ: begin
          if (negative || pos_mag >= len_x) begin
            quick_value  = ils_pkg::MISS_VALUE;
            quick_status = ils_pkg::ST_RANGE;
          end else begin
            quick_done     = 1'b0;
            read_go        = 1'b1;
            ctrl.load_pipe = 1'b1;
          end
        end
        ils_pkg::CMD_INS_AT, ils_pkg::CMD_INS_FRONT, ils_pkg::CMD_INS_BACK: begin
          if (command.cmd == ils_pkg::CMD_INS_FRONT) begin
            cell_pos = '0;
          end else if (command.cmd == ils_pkg::CMD_INS_BACK) begin
            cell_pos = len_x;
          end
          if (cell_pos > len_x) begin
            quick_status = ils_pkg::ST_RANGE;
          end else if (length == FULL_COUNT) begin
            quick_status = ils_pkg::ST_FULL;
          end else begin
            ctrl.insert = 1'b1;
            length_next = length + CNT_W'(1);
          end
        end
        ils_pkg::CMD_DELETE: begin
          if (negative || pos_mag >= len_x) begin
            quick_value  = ils_pkg::MISS_VALUE;
            quick_status = ils_pkg::ST_RANGE;
          end else begin
            ctrl.remove = 1'b1;
            length_next = length - CNT_W'(1);
          end
        end
        default: begin
          quick_status = ils_pkg::ST_RANGE;
        end
      endcase
    end else if (busy && read_left != '0) begin
      ctrl.shift_pipe = 1'b1;
    end
  end

  // row of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [ils_pkg::DATA_W-1:0] left_v;
    logic [ils_pkg::DATA_W-1:0] right_v;
    logic [ils_pkg::DATA_W-1:0] right_p;
    if (i == 0) begin : g_first
      assign left_v = '0;
    end else begin : g_mid_l
      assign left_v = cell_value[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_v = '0;
      assign right_p = '0;
    end else begin : g_mid_r
      assign right_v = cell_value[i+1];
      assign right_p = cell_pipe[i+1];
    end
    ils_cell #(
      .INDEX (i),
      .IDX_W (CMP_W)
    ) u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .pos         (cell_pos),
      .left_value  (left_v),
      .right_value (right_v),
      .right_pipe  (right_p),
      .value       (cell_value[i]),
      .pipe        (cell_pipe[i])
    );
  end

  // count, read sequencing and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      length    <= '0;
      busy      <= 1'b0;
      done      <= 1'b0;
      read_left <= '0;
    end else begin
      length <= length_next;
      done   <= quick_done || (busy && read_left == '0);
      if (read_go) begin
        busy      <= 1'b1;
        read_left <= pos_mag;
      end else if (busy) begin
        if (read_left == '0) begin
          busy <= 1'b0;
        end else begin
          read_left <= read_left - CMP_W'(1);
        end
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (quick_done) begin
      result.read_value <= quick_value;
      result.status     <= quick_status;
      result.item_count <= len_next_x[ils_pkg::COUNT_W-1:0];
    end else if (busy && read_left == '0) begin
      result.read_value <= cell_pipe[0];
      result.status     <= ils_pkg::ST_DONE;
      result.item_count <= len_x[ils_pkg::COUNT_W-1:0];
    end
  end

endmodule

### bench/indexed_list_store_check.sv
// ----------------------------------------------------------------------------
// indexed_list_store_check: result predictor and comparator
// Watches command transfers on start/busy and predicts each response from a
// queue-based copy of the stored sequence. Every strobed result on done is
// compared field by field against the oldest pending prediction. The
// mismatch count, the number of pending predictions and the predicted
// length go back to the testbench top.
// ----------------------------------------------------------------------------
module indexed_list_store_check #(
  parameter int CAPACITY = 1024
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             busy,
  input  ils_pkg::cmd_t    command,
  input  logic             done,
  input  ils_pkg::result_t result,
  output int               fail_count,
  output int               pending,
  output int               stored
);
  timeunit 1ns;
  timeprecision 1ps;

  // predicted contents, front of the sequence at index 0
  logic signed [ils_pkg::DATA_W-1:0] values_q[$];
  // predicted responses still in flight
  ils_pkg::result_t responses_q[$];

  // insert one value, with the past-end check ahead of the full check
  function automatic logic [ils_pkg::STATUS_W-1:0] place_value(
      int pos, logic signed [ils_pkg::DATA_W-1:0] v);
    if (pos > values_q.size()) return ils_pkg::ST_RANGE;
    if (values_q.size() >= CAPACITY) return ils_pkg::ST_FULL;
    values_q.insert(pos, v);
    return ils_pkg::ST_DONE;
  endfunction

  // apply one command to the predicted contents and form its response
  function automatic ils_pkg::result_t apply_command(ils_pkg::cmd_t c);
    ils_pkg::result_t r;
    logic             negative;
    int               pos;
    negative = c.position[ils_pkg::POS_W-1];
    pos      = negative ? 0 : int'(c.position);
    r        = '0;
    case (c.cmd)
      ils_pkg::CMD_READ: begin
        if (negative || pos >= values_q.size()) begin
          r.read_value = ils_pkg::MISS_VALUE;
          r.status     = ils_pkg::ST_RANGE;
        end else begin
          r.read_value = values_q[pos];
        end
      end
      ils_pkg::CMD_INS_AT:    r.status = place_value(pos, c.value_in);
      ils_pkg::CMD_INS_FRONT: r.status = place_value(0, c.value_in);
      ils_pkg::CMD_INS_BACK:  r.status = place_value(values_q.size(), c.value_in);
      ils_pkg::CMD_DELETE: begin
        if (negative || pos >= values_q.size()) begin
          r.read_value = ils_pkg::MISS_VALUE;
          r.status     = ils_pkg::ST_RANGE;
        end else begin
          values_q.delete(pos);
        end
      end
      default: r.status = ils_pkg::ST_RANGE;
    endcase
    r.item_count = ils_pkg::COUNT_W'(values_q.size());
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [ils_pkg::DATA_W-1:0] want,
                                 logic [ils_pkg::DATA_W-1:0] got);
    if (fail_count < 200)
      $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, what, want, got);
    fail_count++;
  endtask

  // compare strobed results first, then record the command transfer
  always @(posedge clk) begin : watch
    ils_pkg::result_t want;
    if (rst) begin
      values_q.delete();
      responses_q.delete();
    end else begin
      if (done) begin
        if (responses_q.size() == 0) begin
          report_mismatch("unexpected result", '0, result.read_value);
        end else begin
          want = responses_q.pop_front();
          if (result.read_value !== want.read_value)
            report_mismatch("read_value", want.read_value, result.read_value);
          if (result.status !== want.status)
            report_mismatch("status", ils_pkg::DATA_W'(want.status),
                            ils_pkg::DATA_W'(result.status));
          if (result.item_count !== want.item_count)
            report_mismatch("item_count", ils_pkg::DATA_W'(want.item_count),
                            ils_pkg::DATA_W'(result.item_count));
        end
      end
      if (start && !busy) responses_q.push_back(apply_command(command));
    end
    pending <= responses_q.size();
    stored  <= values_q.size();
  end

endmodule

### bench/indexed_list_store_tb.sv
// ----------------------------------------------------------------------------
// indexed_list_store_tb: testbench top of the indexed list store
// Drives a short directed sequence over empty, boundary and rejected
// commands, then random traffic that mixes commands, grows the store, probes
// its far end and drains it again. Random gaps sit between transfers; the
// checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module indexed_list_store_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAPACITY    = 1024;
  localparam int MIXED_ITEMS = 100;
  localparam int GROW_ITEMS  = 150;
  localparam int PHASE_BOUND = 120;
  localparam int TAIL_ITEMS  = 60;
  localparam int ITEM_BOUND  = 40 + MIXED_ITEMS + GROW_ITEMS + 8 + PHASE_BOUND
                               + TAIL_ITEMS;
  // every item at its longest gap and deepest read, twice over
  localparam int CYCLE_LIMIT = ITEM_BOUND * (CAPACITY + 12) * 2;

  logic             clk = 1'b0;
  logic             rst;
  logic             start;
  logic             busy;
  logic             done;
  ils_pkg::cmd_t    command;
  ils_pkg::result_t result;
  int               fail_count;
  int               pending;
  int               stored;
  int               cycles = 0;
  int               burst_left = 0;
  int               guard;

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  indexed_list_store #(
    .CAPACITY(CAPACITY)
  ) uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .command(command),
    .done(done),
    .result(result)
  );

  indexed_list_store_check #(
    .CAPACITY(CAPACITY)
  ) u_check (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .command(command),
    .done(done),
    .result(result),
    .fail_count(fail_count),
    .pending(pending),
    .stored(stored)
  );

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic ils_pkg::cmd_t make_cmd(logic [ils_pkg::CMD_W-1:0] op, int pos,
                                             logic [ils_pkg::DATA_W-1:0] v);
    ils_pkg::cmd_t c;
    c.cmd      = op;
    c.position = ils_pkg::POS_W'(pos);
    c.value_in = v;
    return c;
  endfunction

  // position mostly in range and small, sometimes deep, past the end or anywhere
  function automatic int pick_position(int len, int past_end);
    int hi;
    int roll;
    hi   = len - 1 + past_end;
    roll = $urandom_range(0, 19);
    if (roll == 0) return int'($urandom_range(0, 4095)) - 2048;
    if (roll == 1 || hi < 0) return hi + 1;
    if (roll < 5) return int'($urandom_range(0, hi));
    return int'($urandom_range(0, hi < 15 ? hi : 15));
  endfunction

  // random command with the given insert and delete weights in percent
  function automatic ils_pkg::cmd_t rand_command(int len, int ins_pct, int del_pct);
    ils_pkg::cmd_t c;
    int            roll;
    roll       = $urandom_range(0, 99);
    c.value_in = $urandom;
    c.position = ils_pkg::POS_W'($urandom);
    if (roll < ins_pct) begin
      case ($urandom_range(0, 2))
        0:       c.cmd = ils_pkg::CMD_INS_FRONT;
        1:       c.cmd = ils_pkg::CMD_INS_BACK;
        default: c.cmd = ils_pkg::CMD_INS_AT;
      endcase
      c.position = ils_pkg::POS_W'(pick_position(len, 1));
    end else if (roll < ins_pct + del_pct) begin
      c.cmd      = ils_pkg::CMD_DELETE;
      c.position = ils_pkg::POS_W'(pick_position(len, 0));
    end else if (roll < 97) begin
      c.cmd      = ils_pkg::CMD_READ;
      c.position = ils_pkg::POS_W'(pick_position(len, 0));
    end else begin
      // opcodes above delete are undefined
      c.cmd = ils_pkg::CMD_W'(ils_pkg::CMD_DELETE + $urandom_range(1, 3));
    end
    return c;
  endfunction

  // hold off new commands until every pending result has come back
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // one command transfer after a random gap
  task automatic send(ils_pkg::cmd_t c);
    int gap;
    if ($urandom_range(0, 49) == 0) drain_results();
    if (burst_left > 0) begin
      burst_left--;
      gap = 0;
    end else if ($urandom_range(0, 29) == 0) begin
      burst_left = $urandom_range(8, 24);
      gap = 0;
    end else begin
      gap = $urandom_range(0, 7);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    command <= c;
    do @(posedge clk); while (busy);
  endtask

  initial begin
    rst     = 1'b1;
    start   = 1'b0;
    command = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // empty store and inserts past the end
    send(make_cmd(ils_pkg::CMD_READ, 0, 0));
    send(make_cmd(ils_pkg::CMD_DELETE, 0, 0));
    send(make_cmd(ils_pkg::CMD_INS_AT, 1, 32'h0000_0005));
    // negative insert position lands at the front
    send(make_cmd(ils_pkg::CMD_INS_AT, -2048, 32'h7FFF_FFFF));
    send(make_cmd(ils_pkg::CMD_INS_FRONT, 0, 32'h8000_0000));
    send(make_cmd(ils_pkg::CMD_INS_BACK, 2047, 32'hFFFF_FFFF));
    send(make_cmd(ils_pkg::CMD_INS_AT, 3, 32'h0000_0000));
    send(make_cmd(ils_pkg::CMD_INS_AT, 1, 32'h5555_AAAA));
    send(make_cmd(ils_pkg::CMD_INS_AT, 2047, 32'h0000_0001));
    // reads across the sequence and out of range on both sides
    for (int k = 0; k <= 5; k++) send(make_cmd(ils_pkg::CMD_READ, k, $urandom));
    send(make_cmd(ils_pkg::CMD_READ, -1, 0));
    send(make_cmd(ils_pkg::CMD_READ, 2047, 0));
    send(make_cmd(ils_pkg::CMD_READ, -2048, 0));
    // deletes in the middle, negative, past the end and at the front
    send(make_cmd(ils_pkg::CMD_DELETE, 2, 0));
    send(make_cmd(ils_pkg::CMD_DELETE, -1, 0));
    send(make_cmd(ils_pkg::CMD_DELETE, 4, 0));
    send(make_cmd(ils_pkg::CMD_DELETE, 2047, 0));
    for (int k = 1; k <= 3; k++)
      send(make_cmd(ils_pkg::CMD_W'(ils_pkg::CMD_DELETE + k), $urandom_range(0, 4095),
                    $urandom));
    send(make_cmd(ils_pkg::CMD_DELETE, 0, 0));
    drain_results();

    // mixed traffic at low occupancy
    repeat (MIXED_ITEMS) send(rand_command(stored, 45, 20));
    drain_results();

    // grow the store
    repeat (GROW_ITEMS) send(rand_command(stored, 85, 5));
    drain_results();

    // far end of the longer sequence: deepest read, past-end accesses
    send(make_cmd(ils_pkg::CMD_READ, stored - 1, 0));
    send(make_cmd(ils_pkg::CMD_READ, stored, 0));
    send(make_cmd(ils_pkg::CMD_INS_AT, stored + 1, $urandom));
    send(make_cmd(ils_pkg::CMD_DELETE, stored - 1, 0));
    drain_results();

    // drain toward empty
    guard = 0;
    while (stored > 4 && guard < PHASE_BOUND) begin
      send(rand_command(stored, 10, 85));
      guard++;
    end

    // mixed traffic again
    repeat (TAIL_ITEMS) send(rand_command(stored, 40, 35));

    drain_results();
    repeat (16) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0 && pending == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
